// File: src/linear_probing_key_value_table_macros.svh
// Assertion macros for the linear probing key/value table.
`ifndef LINEAR_PROBING_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_PROBING_KEY_VALUE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LPKV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpkv assertion failed");
// next-cycle implication
`define LPKV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpkv assertion failed");
`else
`define LPKV_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define LPKV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/lpkv_pkg.sv
// Package: shared types and codes of the linear probing key/value table.
`timescale 1ns / 1ps
package lpkv_pkg;

   localparam int KEY_W  = 64;
   localparam int VAL_W  = 64;
   localparam int SIZE_W = 11;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [1:0] {
      ACT_ALLOC    = 2'd0,
      ACT_RETRIEVE = 2'd1,
      ACT_DEALLOC  = 2'd2,
      ACT_NOP      = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_MOD,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       clr_wr;
      logic       accept;
      logic       hash_step;
      logic       mod_step;
      logic       probe_start;
      logic       probe_rd;
      logic       probe_next;
      logic       wr_entry;
      logic       wr_unused;
      logic       key_advance;
      logic       status_we;
      status_type status_code;
      logic       rsp_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_last;
      logic       hash_last;
      logic       mod_last;
      logic       slot_used;
      logic       key_match;
      logic       sweep_last;
      logic       rsp_free;
      action_type action;
   } dp_status_type;

endpackage

// File: src/lpkv_req_if.sv
// Interface: request channel of the key/value table.
`timescale 1ns / 1ps
interface lpkv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] key_in;
   logic [63:0] value_in;

   modport source (output valid, output action, output key_in, output value_in,
                   input ready);
   modport sink   (input valid, input action, input key_in, input value_in,
                   output ready);
endinterface

// File: src/lpkv_rsp_if.sv
// Interface: response channel of the key/value table.
`timescale 1ns / 1ps
interface lpkv_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] key_out;
   logic [63:0] value_out;

   modport source (output valid, output status, output key_out, output value_out,
                   input ready);
   modport sink   (input valid, input status, input key_out, input value_out,
                   output ready);
endinterface

// File: src/lpkv_ctrl.sv
// Controller: sequences clear pass, hash, modulo, probing and response.
`timescale 1ns / 1ps
module lpkv_ctrl
   import lpkv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_st,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_DONE;
      req_ready       = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (dp_st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (dp_st.action == ACT_NOP) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = ST_DONE;
               state_in        = S_RESP;
            end else begin
               cmd.hash_step = 1'b1;
               if (dp_st.hash_last) begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (dp_st.mod_last) begin
               cmd.probe_start = 1'b1;
               state_in        = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            cmd.probe_rd = 1'b1;
            state_in     = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            state_in      = S_RESP;
            cmd.status_we = 1'b1;
            if (dp_st.action == ACT_ALLOC) begin
               if (!dp_st.slot_used || dp_st.key_match) begin
                  cmd.wr_entry    = 1'b1;
                  cmd.key_advance = 1'b1;
                  cmd.status_code = ST_DONE;
               end else if (dp_st.sweep_last) begin
                  cmd.status_code = ST_FULL;
               end else begin
                  cmd.status_we  = 1'b0;
                  cmd.probe_next = 1'b1;
                  state_in       = S_PROBE_RD;
               end
            end else begin
               if (!dp_st.slot_used) begin
                  cmd.status_code = ST_NOT_FOUND;
               end else if (dp_st.key_match) begin
                  if (dp_st.action == ACT_RETRIEVE) begin
                     cmd.status_code = ST_FOUND;
                  end else begin
                     cmd.wr_unused   = 1'b1;
                     cmd.status_code = ST_DONE;
                  end
               end else if (dp_st.sweep_last) begin
                  cmd.status_code = ST_NOT_FOUND;
               end else begin
                  cmd.status_we  = 1'b0;
                  cmd.probe_next = 1'b1;
                  state_in       = S_PROBE_RD;
               end
            end
         end
         S_RESP: begin
            if (dp_st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// File: src/lpkv_dp.sv
// Datapath: slot memories, hash, modulo unit, probe counters, output register.
`timescale 1ns / 1ps
`include "linear_probing_key_value_table_macros.svh"
module lpkv_dp
   import lpkv_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  logic [1:0]        req_action,
   input  logic [KEY_W-1:0]  req_key_in,
   input  logic [VAL_W-1:0]  req_value_in,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     dp_st,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [KEY_W-1:0]  rsp_key_out,
   output logic [VAL_W-1:0]  rsp_value_out
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int MOD_BITS = 4;

   // slot memories
   logic             used_mem [SLOTS];
   logic [KEY_W-1:0] key_mem  [SLOTS];
   logic [VAL_W-1:0] val_mem  [SLOTS];

   logic [SIZE_W-1:0] table_size_ff;
   logic [KEY_W-1:0]  next_key_ff;
   action_type        action_ff;
   logic [KEY_W-1:0]  work_key_ff;
   logic [VAL_W-1:0]  work_val_ff;
   logic [KEY_W-1:0]  src_ff, src_in;
   logic [63:0]       hash_ff, hash_in;
   logic [2:0]        hash_cnt_ff;
   logic [3:0]        mod_cnt_ff;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  probes_ff;
   logic [IDX_W-1:0]  clr_idx_ff;
   logic              rd_used_ff;
   logic [KEY_W-1:0]  rd_key_ff;
   logic [VAL_W-1:0]  rd_val_ff;
   status_type        status_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic [VAL_W-1:0]  rsp_val_ff;

   logic [CMP_W-1:0] n_ext;
   logic [CNT_W-1:0] n;
   logic             wrap;
   logic             used_we;
   logic [IDX_W-1:0] used_wa;
   logic             used_wd;

   // effective size: zero acts as one, clamp to SLOTS
   always_comb begin
      n_ext = CMP_W'(table_size_ff);
      if (table_size_ff == '0) begin
         n_ext = CMP_W'(1);
      end else if (CMP_W'(table_size_ff) > CMP_W'(SLOTS)) begin
         n_ext = CMP_W'(SLOTS);
      end
      n = n_ext[CNT_W-1:0];
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         table_size_ff <= csr_wr_data;
      end
   end

   // hash step: h*31 + byte, low byte first
   always_comb begin
      hash_in = (hash_ff << 5) - hash_ff + {56'd0, src_ff[7:0]};
      src_in  = src_ff >> 8;
   end

   // remainder step: four bits of the hash per cycle
   always_comb begin
      logic [CNT_W:0]   t;
      logic [CNT_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         t = {r, hash_ff[63-i]};
         if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
         end
         r = t[CNT_W-1:0];
      end
      rem_in = r;
   end

   // probe index advance with wrap at the table size
   always_comb begin
      wrap   = (CNT_W'(idx_ff) + CNT_W'(1)) == n;
      idx_in = wrap ? '0 : idx_ff + IDX_W'(1);
   end

   // item registers and sequencing counters
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff   <= action_type'(req_action);
         work_key_ff <= (action_type'(req_action) == ACT_ALLOC) ? next_key_ff : req_key_in;
         src_ff      <= (action_type'(req_action) == ACT_ALLOC) ? next_key_ff : req_key_in;
         work_val_ff <= req_value_in;
         hash_ff     <= '0;
         hash_cnt_ff <= '0;
         mod_cnt_ff  <= '0;
         rem_ff      <= '0;
      end
      if (cmd.hash_step) begin
         hash_ff     <= hash_in;
         src_ff      <= src_in;
         hash_cnt_ff <= hash_cnt_ff + 3'd1;
      end
      if (cmd.mod_step) begin
         rem_ff     <= rem_in;
         hash_ff    <= hash_ff << MOD_BITS;
         mod_cnt_ff <= mod_cnt_ff + 4'd1;
      end
      if (cmd.probe_start) begin
         idx_ff    <= rem_in[IDX_W-1:0];
         probes_ff <= '0;
      end
      if (cmd.probe_next) begin
         idx_ff    <= idx_in;
         probes_ff <= probes_ff + CNT_W'(1);
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_code;
      end
   end

   // key counter
   always_ff @(posedge clock) begin
      if (reset) begin
         next_key_ff <= '0;
      end else if (cmd.key_advance) begin
         next_key_ff <= next_key_ff + KEY_W'(1);
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_idx_ff <= clr_idx_ff + IDX_W'(1);
      end
   end

   // used mark write port
   always_comb begin
      used_we = cmd.clr_wr | cmd.wr_entry | cmd.wr_unused;
      used_wa = cmd.clr_wr ? clr_idx_ff : idx_ff;
      used_wd = cmd.wr_entry;
   end

   // memories: one write, registered read
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      if (cmd.wr_entry) begin
         key_mem[idx_ff] <= work_key_ff;
         val_mem[idx_ff] <= work_val_ff;
      end
      if (cmd.probe_rd) begin
         rd_used_ff <= used_mem[idx_ff];
         rd_key_ff  <= key_mem[idx_ff];
         rd_val_ff  <= val_mem[idx_ff];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_key_ff    <= (status_ff == ST_DONE && action_ff == ACT_ALLOC) ?
                          work_key_ff : '0;
         rsp_val_ff    <= (status_ff == ST_FOUND) ? rd_val_ff : '0;
      end
   end

   // status to controller
   always_comb begin
      dp_st.clr_last   = clr_idx_ff == IDX_W'(SLOTS - 1);
      dp_st.hash_last  = hash_cnt_ff == 3'd7;
      dp_st.mod_last   = mod_cnt_ff == 4'd15;
      dp_st.slot_used  = rd_used_ff;
      dp_st.key_match  = rd_key_ff == work_key_ff;
      dp_st.sweep_last = probes_ff == (n - CNT_W'(1));
      dp_st.rsp_free   = !rsp_valid_ff || rsp_ready;
      dp_st.action     = action_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_value_out = rsp_val_ff;

   `LPKV_ASSERT_NOW(a_probe_in_range, clock, reset, cmd.probe_rd, CNT_W'(idx_ff) < n)
   `LPKV_ASSERT_NOW(a_sweep_bound, clock, reset, cmd.probe_rd, probes_ff < n)
   `LPKV_ASSERT_NOW(a_load_when_free, clock, reset, cmd.rsp_load, dp_st.rsp_free)
   `LPKV_ASSERT_NEXT(a_alloc_bumps_key, clock, reset, cmd.key_advance,
                     next_key_ff == $past(next_key_ff) + KEY_W'(1))

endmodule

// File: src/linear_probing_key_value_table.sv
// Top level: linear probing key/value table, controller plus datapath.
//
// Requests arrive on req_ch (action, key_in, value_in) and each gives exactly
// one response on rsp_ch (status, key_out, value_out), in order. An item is
// taken when valid and ready are both high. csr_wr_en writes table_size.
// One item is worked on at a time. From accept to response valid: the hash
// (one key byte per cycle), the modulo (four remainder bits per cycle), then
// per probed slot a memory read state and a compare state, then the load of
// the output register, which waits while the previous response is pending.
// The next item can be taken in the cycle after that load. The unknown action
// skips hash, modulo and probing and goes straight to the response.
// The probe loop over the single-port slot memory sets the item rate.
// After reset a clearing pass writes every used mark to zero, during which
// req_ch.ready is low; table_size returns to 1024, key count 0.
// The response sits in an output register; the next request is accepted and
// worked while it waits, and the block holds only its following result
// until rsp_ch.ready takes the pending one.
`timescale 1ns / 1ps
module linear_probing_key_value_table
   import lpkv_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   lpkv_req_if.sink          req_ch,
   lpkv_rsp_if.source        rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_st;

   lpkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_st     (dp_st),
      .cmd       (cmd)
   );

   lpkv_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_action    (req_ch.action),
      .req_key_in    (req_ch.key_in),
      .req_value_in  (req_ch.value_in),
      .cmd           (cmd),
      .dp_st         (dp_st),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_status    (rsp_ch.status),
      .rsp_key_out   (rsp_ch.key_out),
      .rsp_value_out (rsp_ch.value_out)
   );

endmodule
